### hdl/multi_kind_timer_bank_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timer bank
// Shared checks written in one form across the project.
// ----------------------------------------------------------------------------
`ifndef MULTI_KIND_TIMER_BANK_MACROS_SVH
`define MULTI_KIND_TIMER_BANK_MACROS_SVH

// same-cycle implication
`define MKTB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mktb check failed");

// next-cycle implication
`define MKTB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mktb check failed");

`endif

### hdl/mktb_pkg.sv
// ----------------------------------------------------------------------------
// mktb_pkg
// Constants, codes and types of the timer bank.
// ----------------------------------------------------------------------------
package mktb_pkg;
  localparam int SLOTS = 8;
  localparam int TYPES = 4;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IW = $clog2(TYPES * SLOTS);
  localparam logic [16:0] SKIP_MAX = 17'd131071;

  localparam logic [2:0] KIND_ADD    = 3'd0;
  localparam logic [2:0] KIND_REMOVE = 3'd1;
  localparam logic [2:0] KIND_TICK   = 3'd2;
  localparam logic [2:0] KIND_PROC   = 3'd3;
  localparam logic [2:0] KIND_PAUSE  = 3'd4;
  localparam logic [2:0] KIND_RESUME = 3'd5;

  localparam logic [1:0] TT_COUNTDOWN = 2'd0;
  localparam logic [1:0] TT_STOPWATCH = 2'd1;
  localparam logic [1:0] TT_STEP      = 2'd2;
  localparam logic [1:0] TT_UPDATE    = 2'd3;

  localparam logic [1:0] RES_FIRED = 2'd0;
  localparam logic [1:0] RES_ADDED = 2'd1;
  localparam logic [1:0] RES_FULL  = 2'd2;
  localparam logic [1:0] RES_DONE  = 2'd3;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               sub;
  } alu_req_t;

  typedef struct packed {
    logic signed [31:0] sum;  // saturated a+b or a-b
    logic               lt;   // a < b
  } alu_rsp_t;
endpackage

### hdl/mktb_if.sv
// ----------------------------------------------------------------------------
// mktb channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface mktb_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [1:0]  timer_type;
  logic [2:0]  slot;
  logic [30:0] amount;
  logic [30:0] lifetime;
  logic [15:0] skip_frames;
  logic        repeat_flag;
  modport source (output valid, kind, timer_type, slot, amount, lifetime, skip_frames,
                  repeat_flag, input ready);
  modport sink (input valid, kind, timer_type, slot, amount, lifetime, skip_frames,
                repeat_flag, output ready);
endinterface

interface mktb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [1:0] event_type;
  logic [2:0] event_slot;
  logic       last;
  modport source (output valid, event_res, event_type, event_slot, last, input ready);
  modport sink (input valid, event_res, event_type, event_slot, last, output ready);
endinterface

### hdl/multi_kind_timer_bank.sv
// ----------------------------------------------------------------------------
// multi_kind_timer_bank
// Bank of countdown, stopwatch, step and update timers, SLOTS of each type.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one item per handshake: add, remove, tick, process,
//   pause all or resume all. out_ch returns the results of that item; the
//   final result of every item has last set.
//   Add answers added (with slot) or pool full; process answers one fired
//   result per firing entry, in type then slot order, then done. All other
//   kinds answer a single done.
//   Add loads its result straight from the work state; remove, pause,
//   resume and undefined kinds pass through the done state to load done.
//   Tick and process walk all 4*SLOTS entries through the one shared
//   adder/comparator, one entry a cycle while no fired result stalls.
//   in_ch.ready is high only between items, so one item is in work at a time;
//   with no stall the next item is taken the cycle after the last result loads.
//   The single output register holds a result until taken; while out_ch
//   stalls with a fired result pending, the entry walk waits on it.
//   Reset (rst, synchronous) frees every slot and clears running and saved
//   bits; the block is ready as soon as reset drops.
// ----------------------------------------------------------------------------
`include "multi_kind_timer_bank_macros.svh"

module multi_kind_timer_bank
  import mktb_pkg::*;
(
  input logic        clk,
  input logic        rst,
  mktb_in_if.sink    in_ch,
  mktb_out_if.source out_ch
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WORK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [SW-1:0] S_LAST = SW'(SLOTS - 1);

  logic [1:0] state;

  // latched item
  logic [2:0]  kind;
  logic [1:0]  ttype;
  logic [2:0]  slot;
  logic [30:0] amount;
  logic [30:0] lifetime;
  logic [15:0] skips;
  logic        rep;

  // timer state
  logic [3:0]         used [SLOTS];
  logic [3:0]         running [SLOTS];
  logic [3:0]         saved [SLOTS];
  logic               repeat_bit [SLOTS];
  logic signed [31:0] limit_time [TYPES*SLOTS];
  logic signed [31:0] run_time [TYPES*SLOTS];
  logic signed [31:0] life_time [SLOTS];
  logic [15:0]        skip_limit [SLOTS];
  logic [16:0]        skip_count [SLOTS];

  // entry walk
  logic [1:0]    t_cnt;
  logic [SW-1:0] s_cnt;
  logic [IW-1:0] idx;

  // output register
  logic       ov;
  logic [1:0] o_res, o_type;
  logic [2:0] o_slot;
  logic       o_last;
  logic       out_free;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  mktb_alu u_alu (.req(alu_req), .rsp(alu_rsp));

  // first free slot of the requested type
  logic          found;
  logic [SW-1:0] free_s;
  always_comb begin
    found = 1'b0;
    free_s = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i][ttype]) begin
        found = 1'b1;
        free_s = SW'(i);
      end
    end
  end

  logic entry_used, entry_run, fire, expire, skip_lt, walk_end, go;

  assign idx = IW'(IW'(t_cnt) * IW'(SLOTS) + IW'(s_cnt));
  assign entry_used = used[s_cnt][t_cnt];
  assign entry_run = running[s_cnt][t_cnt];
  assign walk_end = (t_cnt == TT_UPDATE) && (s_cnt == S_LAST);
  assign out_free = !ov || out_ch.ready;
  assign skip_lt = {1'b0, skip_limit[s_cnt]} < skip_count[s_cnt];

  // one operation of the shared unit per entry
  always_comb begin
    alu_req.a = run_time[idx];
    alu_req.b = $signed({1'b0, amount});
    alu_req.sub = 1'b1;
    if (kind == KIND_TICK) begin
      alu_req.sub = (t_cnt == TT_COUNTDOWN);
    end else begin
      case (t_cnt)
        TT_COUNTDOWN: begin
          alu_req.a = run_time[idx];
          alu_req.b = '0;
        end
        TT_UPDATE: begin
          alu_req.a = life_time[s_cnt];
          alu_req.b = run_time[idx];
        end
        default: begin
          alu_req.a = limit_time[idx];
          alu_req.b = run_time[idx];
        end
      endcase
    end
  end

  always_comb begin
    expire = (t_cnt == TT_UPDATE) && alu_rsp.lt;
    fire = (t_cnt == TT_UPDATE) ? (!alu_rsp.lt && skip_lt) : alu_rsp.lt;
    go = !(kind == KIND_PROC && entry_used && fire) || out_free;
  end

  assign in_ch.ready = (state == ST_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      t_cnt <= '0;
      s_cnt <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        used[i] <= '0;
        running[i] <= '0;
        saved[i] <= '0;
        repeat_bit[i] <= 1'b0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            kind <= in_ch.kind;
            ttype <= in_ch.timer_type;
            slot <= in_ch.slot;
            amount <= in_ch.amount;
            lifetime <= in_ch.lifetime;
            skips <= in_ch.skip_frames;
            rep <= in_ch.repeat_flag;
            t_cnt <= '0;
            s_cnt <= '0;
            state <= ST_WORK;
          end
        end
        ST_WORK: begin
          case (kind)
            KIND_ADD: begin
              if (out_free) begin
                if (found) begin
                  used[free_s][ttype] <= 1'b1;
                  running[free_s][ttype] <= 1'b1;
                  case (ttype)
                    TT_COUNTDOWN: begin
                      repeat_bit[free_s] <= rep;
                      limit_time[IW'(free_s)] <= $signed({1'b0, amount});
                      run_time[IW'(free_s)] <= $signed({1'b0, amount});
                    end
                    TT_UPDATE: begin
                      skip_limit[free_s] <= skips;
                      skip_count[free_s] <= {1'b0, skips};
                      life_time[free_s] <= $signed({1'b0, lifetime});
                      run_time[IW'(IW'(3 * SLOTS) + IW'(free_s))] <= '0;
                    end
                    default: begin
                      limit_time[IW'(IW'(ttype) * IW'(SLOTS) + IW'(free_s))] <=
                        $signed({1'b0, amount});
                      run_time[IW'(IW'(ttype) * IW'(SLOTS) + IW'(free_s))] <= '0;
                    end
                  endcase
                end
                state <= ST_IDLE;
              end
            end
            KIND_REMOVE: begin
              if (32'(slot) < 32'(SLOTS)) begin
                used[SW'(slot)][ttype] <= 1'b0;
                running[SW'(slot)][ttype] <= 1'b0;
                if (ttype == TT_COUNTDOWN) begin
                  repeat_bit[SW'(slot)] <= 1'b0;
                end else begin
                  run_time[IW'(IW'(ttype) * IW'(SLOTS) + IW'(SW'(slot)))] <= '0;
                end
                if (ttype == TT_UPDATE) begin
                  skip_limit[SW'(slot)] <= '0;
                end
              end
              state <= ST_DONE;
            end
            KIND_PAUSE: begin
              for (int i = 0; i < SLOTS; i++) begin
                saved[i] <= running[i];
                running[i] <= '0;
              end
              state <= ST_DONE;
            end
            KIND_RESUME: begin
              for (int i = 0; i < SLOTS; i++) begin
                running[i] <= saved[i];
              end
              state <= ST_DONE;
            end
            KIND_TICK, KIND_PROC: begin
              if (go) begin
                if (kind == KIND_TICK) begin
                  if (entry_used && entry_run) begin
                    run_time[idx] <= alu_rsp.sum;
                    if (t_cnt == TT_UPDATE && skip_count[s_cnt] < SKIP_MAX) begin
                      skip_count[s_cnt] <= skip_count[s_cnt] + 17'd1;
                    end
                  end
                end else if (entry_used) begin
                  case (t_cnt)
                    TT_COUNTDOWN: begin
                      if (fire) begin
                        run_time[idx] <= limit_time[idx];
                        if (!repeat_bit[s_cnt]) begin
                          used[s_cnt][0] <= 1'b0;
                          running[s_cnt][0] <= 1'b0;
                          repeat_bit[s_cnt] <= 1'b0;
                        end
                      end
                    end
                    TT_STOPWATCH: begin
                      if (fire) begin
                        used[s_cnt][1] <= 1'b0;
                        running[s_cnt][1] <= 1'b0;
                        run_time[idx] <= '0;
                      end
                    end
                    TT_STEP: begin
                      if (fire) begin
                        run_time[idx] <= '0;
                      end
                    end
                    default: begin
                      if (expire) begin
                        used[s_cnt][3] <= 1'b0;
                        running[s_cnt][3] <= 1'b0;
                        run_time[idx] <= '0;
                        skip_limit[s_cnt] <= '0;
                      end else if (fire) begin
                        skip_count[s_cnt] <= '0;
                      end
                    end
                  endcase
                end
                if (walk_end) begin
                  state <= ST_DONE;
                end else if (s_cnt == S_LAST) begin
                  s_cnt <= '0;
                  t_cnt <= t_cnt + 2'd1;
                end else begin
                  s_cnt <= s_cnt + SW'(1);
                end
              end
            end
            default: begin
              state <= ST_DONE;
            end
          endcase
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result register
  logic emit_add, emit_fire, emit_done;
  assign emit_add = (state == ST_WORK) && (kind == KIND_ADD) && out_free;
  assign emit_fire = (state == ST_WORK) && (kind == KIND_PROC) && entry_used && fire &&
                     out_free;
  assign emit_done = (state == ST_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (emit_add || emit_fire || emit_done) begin
      ov <= 1'b1;
    end else if (out_ch.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_add) begin
      o_res <= found ? RES_ADDED : RES_FULL;
      o_type <= ttype;
      o_slot <= found ? 3'(free_s) : 3'd0;
      o_last <= 1'b1;
    end else if (emit_fire) begin
      o_res <= RES_FIRED;
      o_type <= t_cnt;
      o_slot <= 3'(s_cnt);
      o_last <= 1'b0;
    end else if (emit_done) begin
      o_res <= RES_DONE;
      o_type <= '0;
      o_slot <= '0;
      o_last <= 1'b1;
    end
  end

  assign out_ch.valid = ov;
  assign out_ch.event_res = o_res;
  assign out_ch.event_type = o_type;
  assign out_ch.event_slot = o_slot;
  assign out_ch.last = o_last;

  `MKTB_ASSERT_NEXT(a_accept_busy, in_ch.valid && in_ch.ready, state != ST_IDLE)
  `MKTB_ASSERT_NEXT(a_done_last, emit_done, ov && o_last && o_res == RES_DONE)
  `MKTB_ASSERT_NOW(a_fire_walk, emit_fire, kind == KIND_PROC && state == ST_WORK)
  `MKTB_ASSERT_NEXT(a_stall_hold, ov && !out_ch.ready && state == ST_WORK &&
                    kind == KIND_PROC && entry_used && fire, $stable(idx))
endmodule

### hdl/mktb_alu.sv
// ----------------------------------------------------------------------------
// mktb_alu
// Shared saturating add/subtract and signed compare.
// ----------------------------------------------------------------------------
module mktb_alu
  import mktb_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);
  logic signed [32:0] ax, bx, res, diff;

  always_comb begin
    ax = {req.a[31], req.a};
    bx = {req.b[31], req.b};
    diff = ax - bx;
    res = req.sub ? diff : (ax + bx);
    rsp.lt = diff[32];
    if (res[32] != res[31]) begin
      rsp.sum = res[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      rsp.sum = res[31:0];
    end
  end
endmodule
